// ===== rtl/core/eip_pkg.sv =====
// Shared types, codes and constants for the Ethernet/IPv4/L4 header parser.
`timescale 1ns / 1ps

package eip_pkg;

  localparam int ETH_HDR_BYTES_DEF = 14;
  localparam int OFFSET_WIDTH_DEF  = 11;
  localparam int IP_FIXED_BYTES    = 20;

  localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [5:0]  MIN_IHL_BYTES  = 6'd20;
  localparam logic [5:0]  UDP_HDR_BYTES  = 6'd8;

  // byte positions inside the IPv4 header
  localparam logic [4:0] IP_B_VER_IHL = 5'd0;
  localparam logic [4:0] IP_B_TOS     = 5'd1;
  localparam logic [4:0] IP_B_LEN_HI  = 5'd2;
  localparam logic [4:0] IP_B_LEN_LO  = 5'd3;
  localparam logic [4:0] IP_B_ID_HI   = 5'd4;
  localparam logic [4:0] IP_B_ID_LO   = 5'd5;
  localparam logic [4:0] IP_B_TTL     = 5'd8;
  localparam logic [4:0] IP_B_PROTO   = 5'd9;
  localparam logic [4:0] IP_B_SRC     = 5'd12;
  localparam logic [4:0] IP_B_DST     = 5'd16;

  // byte positions inside the TCP/UDP header
  localparam logic [1:0] L4_B_SRC_HI = 2'd0;
  localparam logic [1:0] L4_B_SRC_LO = 2'd1;
  localparam logic [1:0] L4_B_DST_HI = 2'd2;
  localparam logic [1:0] L4_B_DST_LO = 2'd3;
  localparam int         L4_PORT_BYTES = 4;
  localparam int         L4_DOFF_POS   = 12;
  // shortest frame tails that still hold what each protocol needs
  localparam int         TCP_MIN_BYTES = L4_DOFF_POS + 1;
  localparam int         UDP_MIN_BYTES = L4_PORT_BYTES;

  typedef enum logic [2:0] {
    ST_NOT_IP   = 3'd0,
    ST_TCP      = 3'd1,
    ST_UDP      = 3'd2,
    ST_OTHER_IP = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [5:0]  ip_header_bytes;
    logic [5:0]  l4_header_bytes;
    logic [7:0]  ttl;
    logic [7:0]  type_of_service;
    logic [15:0] ident;
  } result_t;

endpackage

// ===== rtl/core/eip_in_reg.sv =====
// Input register: holds one frame byte in front of the parse logic.
`timescale 1ns / 1ps

module eip_in_reg
  import eip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       hold,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!hold) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/core/eip_parse.sv =====
// Frame offset tracking, header field capture and the end-of-frame verdict.
`timescale 1ns / 1ps

module eip_parse
  import eip_pkg::*;
#(
  parameter int ETH_HEADER_BYTES = ETH_HDR_BYTES_DEF,
  parameter int OFFSET_WIDTH     = OFFSET_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t result
);

  localparam int CW = OFFSET_WIDTH + 1;
  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
  localparam logic [CW-1:0] ETH_C    = CW'(ETH_HEADER_BYTES);
  localparam logic [CW-1:0] IP_END_C = CW'(ETH_HEADER_BYTES + IP_FIXED_BYTES);

  logic [OFFSET_WIDTH-1:0] offset_r, offset_nxt;
  logic [15:0] ethertype_r, ethertype_nxt;
  logic [5:0]  ihl_r, ihl_nxt;
  logic [7:0]  tos_r, tos_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_addr_r, src_addr_nxt;
  logic [31:0] dst_addr_r, dst_addr_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [5:0]  l4_len_r, l4_len_nxt;

  logic [CW-1:0] off_w, ip_diff, l4_base, l4_diff, len;
  logic [4:0]    ip_k;
  logic [7:0]    b;
  status_t       status;

  assign b       = item.data_byte;
  assign off_w   = {1'b0, offset_r};
  assign ip_diff = off_w - ETH_C;
  assign ip_k    = ip_diff[4:0];
  assign l4_base = ETH_C + CW'(ihl_r);
  assign l4_diff = off_w - l4_base;
  assign len     = off_w + CW'(1);

  // field capture for the current byte
  always_comb begin
    offset_nxt    = (offset_r < OFF_MAX) ? offset_r + OFFSET_WIDTH'(1) : offset_r;
    ethertype_nxt = ethertype_r;
    ihl_nxt       = ihl_r;
    tos_nxt       = tos_r;
    total_len_nxt = total_len_r;
    ident_nxt     = ident_r;
    ttl_nxt       = ttl_r;
    proto_nxt     = proto_r;
    src_addr_nxt  = src_addr_r;
    dst_addr_nxt  = dst_addr_r;
    sport_nxt     = sport_r;
    dport_nxt     = dport_r;
    l4_len_nxt    = l4_len_r;

    if (off_w == ETH_C - CW'(2) || off_w == ETH_C - CW'(1)) begin
      ethertype_nxt = {ethertype_r[7:0], b};
    end

    if (off_w >= ETH_C && off_w < IP_END_C) begin
      case (ip_k)
        IP_B_VER_IHL: ihl_nxt = {b[3:0], 2'b00};
        IP_B_TOS:     tos_nxt = b;
        IP_B_LEN_HI:  total_len_nxt[15:8] = b;
        IP_B_LEN_LO:  total_len_nxt[7:0]  = b;
        IP_B_ID_HI:   ident_nxt[15:8] = b;
        IP_B_ID_LO:   ident_nxt[7:0]  = b;
        IP_B_TTL:     ttl_nxt = b;
        IP_B_PROTO:   proto_nxt = b;
        default: begin
          // address bytes arrive most significant first
          if (ip_k >= IP_B_DST) begin
            dst_addr_nxt[{~ip_k[1:0], 3'b000} +: 8] = b;
          end else if (ip_k >= IP_B_SRC) begin
            src_addr_nxt[{~ip_k[1:0], 3'b000} +: 8] = b;
          end
        end
      endcase
    end

    // L4 header starts right after the IHL captured earlier in this frame
    if (off_w > ETH_C && off_w >= l4_base) begin
      if (l4_diff < CW'(L4_PORT_BYTES)) begin
        case (l4_diff[1:0])
          L4_B_SRC_HI: sport_nxt[15:8] = b;
          L4_B_SRC_LO: sport_nxt[7:0]  = b;
          L4_B_DST_HI: dport_nxt[15:8] = b;
          L4_B_DST_LO: dport_nxt[7:0]  = b;
          default:     sport_nxt = sport_r;
        endcase
      end else if (l4_diff == CW'(L4_DOFF_POS)) begin
        l4_len_nxt = {b[7:4], 2'b00};
      end
    end
  end

  // verdict, using this byte's captures
  always_comb begin
    if (len < ETH_C) begin
      status = ST_BAD;
    end else if (ethertype_nxt != IPV4_ETHERTYPE) begin
      status = ST_NOT_IP;
    end else if (ihl_nxt < MIN_IHL_BYTES || len < ETH_C + CW'(ihl_nxt)) begin
      status = ST_BAD;
    end else if (proto_nxt == PROTO_TCP) begin
      status = (len < ETH_C + CW'(ihl_nxt) + CW'(TCP_MIN_BYTES)) ? ST_BAD : ST_TCP;
    end else if (proto_nxt == PROTO_UDP) begin
      status = (len < ETH_C + CW'(ihl_nxt) + CW'(UDP_MIN_BYTES)) ? ST_BAD : ST_UDP;
    end else begin
      status = ST_OTHER_IP;
    end

    result        = '0;
    result.status = status;
    if (status != ST_NOT_IP) begin
      result.src_addr        = src_addr_nxt;
      result.dst_addr        = dst_addr_nxt;
      result.ip_total_length = total_len_nxt;
      result.ip_protocol     = proto_nxt;
      result.ip_header_bytes = ihl_nxt;
      result.ttl             = ttl_nxt;
      result.type_of_service = tos_nxt;
      result.ident           = ident_nxt;
    end
    if (status == ST_TCP || status == ST_UDP) begin
      result.sport           = sport_nxt;
      result.dport           = dport_nxt;
      result.l4_header_bytes = (status == ST_TCP) ? l4_len_nxt : UDP_HDR_BYTES;
    end
  end

  // all per-frame state returns to zero after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      offset_r    <= '0;
      ethertype_r <= '0;
      ihl_r       <= '0;
      tos_r       <= '0;
      total_len_r <= '0;
      ident_r     <= '0;
      ttl_r       <= '0;
      proto_r     <= '0;
      src_addr_r  <= '0;
      dst_addr_r  <= '0;
      sport_r     <= '0;
      dport_r     <= '0;
      l4_len_r    <= '0;
    end else if (step) begin
      offset_r    <= offset_nxt;
      ethertype_r <= ethertype_nxt;
      ihl_r       <= ihl_nxt;
      tos_r       <= tos_nxt;
      total_len_r <= total_len_nxt;
      ident_r     <= ident_nxt;
      ttl_r       <= ttl_nxt;
      proto_r     <= proto_nxt;
      src_addr_r  <= src_addr_nxt;
      dst_addr_r  <= dst_addr_nxt;
      sport_r     <= sport_nxt;
      dport_r     <= dport_nxt;
      l4_len_r    <= l4_len_nxt;
    end
  end

endmodule

// ===== rtl/core/eip_out_reg.sv =====
// Result register: holds one parse result until the downstream side takes it.
`timescale 1ns / 1ps

module eip_out_reg
  import eip_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/eth_ipv4_l4_header_parser_unit.sv =====
// Top level of the Ethernet/IPv4/TCP-UDP header parser.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_stall   | data_byte, last_byte
//   out_    | output    | out_valid/out_stall | status, addresses, ports, IP fields
//
// One byte per clock is taken while in_stall is low; out_valid for a frame rises once
// its last byte has passed the input register and then loaded the result register.
// Bytes keep flowing while a result waits; only a last byte stalls, and only
// when the result register is still full and the output is stalled.
// rst_n is synchronous; reset clears the frame offset and all captured fields.
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_unit
  import eip_pkg::*;
#(
  parameter int ETH_HEADER_BYTES = ETH_HDR_BYTES_DEF,
  parameter int OFFSET_WIDTH     = OFFSET_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [15:0] out_sport,
  output logic [15:0] out_dport,
  output logic [15:0] out_ip_total_length,
  output logic [7:0]  out_ip_protocol,
  output logic [5:0]  out_ip_header_bytes,
  output logic [5:0]  out_l4_header_bytes,
  output logic [7:0]  out_ttl,
  output logic [7:0]  out_type_of_service,
  output logic [15:0] out_ident
);

  logic    item_valid, advance, step;
  item_t   item;
  result_t res, out_res;

  // a byte moves on unless it ends a frame and the result slot is blocked
  assign advance  = !item.last_byte || !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;
  assign step     = item_valid && advance;

  eip_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (in_stall),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .item_valid   (item_valid),
    .item         (item)
  );

  eip_parse #(
    .ETH_HEADER_BYTES (ETH_HEADER_BYTES),
    .OFFSET_WIDTH     (OFFSET_WIDTH)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .result (res)
  );

  eip_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && item.last_byte),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_status          = out_res.status;
  assign out_src_addr        = out_res.src_addr;
  assign out_dst_addr        = out_res.dst_addr;
  assign out_sport           = out_res.sport;
  assign out_dport           = out_res.dport;
  assign out_ip_total_length = out_res.ip_total_length;
  assign out_ip_protocol     = out_res.ip_protocol;
  assign out_ip_header_bytes = out_res.ip_header_bytes;
  assign out_l4_header_bytes = out_res.l4_header_bytes;
  assign out_ttl             = out_res.ttl;
  assign out_type_of_service = out_res.type_of_service;
  assign out_ident           = out_res.ident;

endmodule
